// ----- rtl/lcs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types, constants and the sigmoid table of the linear classifier core.
// ----------------------------------------------------------------------------
package lcs_pkg;

  localparam int MaxFeatures = 1024;
  localparam int FeatAw      = $clog2(MaxFeatures);
  localparam int SigDepth    = 1024;
  localparam int SigAw       = $clog2(SigDepth);

  typedef enum logic {
    ActLoad  = 1'b0,
    ActScore = 1'b1
  } action_e;

  typedef enum logic {
    CfgBias     = 1'b0,
    CfgInvScale = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic               action;
    logic [9:0]         index;
    logic signed [31:0] weight;
    logic [15:0]        mean;
    logic [15:0]        beta;
    logic               beta_missing;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic        label;
    logic [15:0] probability;
    logic [15:0] confidence;
  } out_item_t;

  typedef enum logic [3:0] {
    CoreIdle,
    CoreMul,
    CoreAcc,
    CoreMag,
    CoreHi,
    CoreLo,
    CoreLogit,
    CoreIndex,
    CoreTable,
    CoreProb,
    CoreEnt,
    CoreOut
  } core_state_e;

  typedef enum logic [2:0] {
    EntIdle,
    EntNorm,
    EntSquare,
    EntTerm,
    EntDone
  } ent_state_e;

  typedef struct packed {
    logic        start;
    logic [15:0] prob;
  } ent_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] conf;
  } ent_rsp_t;

  typedef logic [16:0] sig_tab_t [SigDepth];

  // unsigned 64-bit quotient by shift and subtract (table build only)
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // 1 / (1 + e^-x) at bin midpoints, Q0.16 (top entry may reach 65536)
  function automatic sig_tab_t build_sig_table();
    sig_tab_t    tab;
    logic [63:0] y, pos, neg, term, half, full, e, s;
    y    = 64'd1 << (35 - SigAw);
    pos  = 64'd1 << 32;
    neg  = 64'd0;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = udiv64((term * y) >> 32, 64'(k));
      if (k[0]) neg = neg + term;
      else pos = pos + term;
    end
    half = pos - neg;
    full = (half * half + (64'd1 << 31)) >> 32;
    e    = half;
    for (int i = 0; i < SigDepth; i++) begin
      s      = (64'd1 << 32) + e;
      tab[i] = 17'(udiv64((64'd1 << 48) + (s >> 1), s));
      e      = (e * full + (64'd1 << 31)) >> 32;
    end
    return tab;
  endfunction

  localparam sig_tab_t SigTable = build_sig_table();

endpackage

// ----- rtl/lcs_entropy.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcs_entropy
// Binary-entropy confidence of a Q0.16 probability, one log2 squaring a cycle.
// ----------------------------------------------------------------------------
module lcs_entropy (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcs_pkg::ent_req_t req_i,
  output lcs_pkg::ent_rsp_t rsp_o
);

  lcs_pkg::ent_state_e state_q, state_d;
  logic [3:0]  cnt_q;
  logic [16:0] v_q, q_q;
  logic        pass_q;
  logic [4:0]  k_q;
  logic [31:0] m_q;
  logic [15:0] frac_q;
  logic [39:0] h_q;

  logic [4:0]  k_c;
  logic [46:0] norm_c;
  logic [63:0] sq_c;
  logic [31:0] mn_c;
  logic [20:0] diff_c;
  logic [37:0] term_c;
  logic [39:0] hr_c;
  logic [23:0] h16_c;
  logic [16:0] conf_c;

  always_comb begin
    k_c = '0;
    for (int i = 0; i < 17; i++) begin
      if (v_q[i]) k_c = 5'(i);
    end
  end

  assign norm_c = {30'd0, v_q} << (5'd30 - k_c);
  assign sq_c   = 64'(m_q) * 64'(m_q);
  assign mn_c   = sq_c[61:30];
  assign diff_c = 21'(1 << 20) - {k_q, frac_q};
  assign term_c = 38'(v_q) * 38'(diff_c);
  assign hr_c   = h_q + 40'd32768;
  assign h16_c  = hr_c[39:16];

  always_comb begin
    if (h16_c >= 24'd65536) conf_c = '0;
    else conf_c = 17'd65536 - h16_c[16:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcs_pkg::EntIdle:   if (req_i.start) state_d = lcs_pkg::EntNorm;
      lcs_pkg::EntNorm: begin
        if (v_q != '0) state_d = lcs_pkg::EntSquare;
        else if (pass_q) state_d = lcs_pkg::EntDone;
      end
      lcs_pkg::EntSquare: if (cnt_q == 4'd15) state_d = lcs_pkg::EntTerm;
      lcs_pkg::EntTerm:   state_d = pass_q ? lcs_pkg::EntDone : lcs_pkg::EntNorm;
      lcs_pkg::EntDone:   state_d = lcs_pkg::EntIdle;
      default:            state_d = lcs_pkg::EntIdle;
    endcase
  end

  // outputs
  always_comb begin
    rsp_o.done = (state_q == lcs_pkg::EntDone);
    rsp_o.conf = conf_c[16] ? 16'hFFFF : conf_c[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lcs_pkg::EntIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == lcs_pkg::EntSquare) cnt_q <= cnt_q + 4'd1;
      else cnt_q <= '0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      lcs_pkg::EntIdle: begin
        v_q    <= {1'b0, req_i.prob};
        q_q    <= 17'd65536 - {1'b0, req_i.prob};
        pass_q <= 1'b0;
        h_q    <= '0;
      end
      lcs_pkg::EntNorm: begin
        k_q    <= k_c;
        m_q    <= norm_c[31:0];
        frac_q <= '0;
        if (v_q == '0) begin
          v_q    <= q_q;
          pass_q <= 1'b1;
        end
      end
      lcs_pkg::EntSquare: begin
        m_q    <= mn_c[31] ? {1'b0, mn_c[31:1]} : mn_c;
        frac_q <= {frac_q[14:0], mn_c[31]};
      end
      lcs_pkg::EntTerm: begin
        h_q    <= h_q + 40'(term_c);
        v_q    <= q_q;
        pass_q <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/linear_classifier_score_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_classifier_score_core
// Binary linear classifier: weight/mean stores, saturating score, sigmoid and
// entropy confidence.
// ----------------------------------------------------------------------------
// One item at a time. A load item writes weight and mean into two 1024-entry
// stores, each with a write port and a read port. A feature item runs through
// store read (registered), multiply and saturating 64-bit accumulate. The
// item marked last then runs the result sequencer: magnitude, two 32x32
// partial products for |score| * inv_scale, logit clamp, table index, sigmoid
// ROM read, then the entropy unit at one log2 squaring step per cycle over
// both p and 1-p, and the result item is then registered. The result waits in
// the output register and only the next result blocks on it. Store entries
// are undefined until loaded.
// ----------------------------------------------------------------------------
module linear_classifier_score_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lcs_pkg::in_item_t in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lcs_pkg::out_item_t out_item_o,
  input  logic              cfg_we_i,
  input  logic              cfg_index_i,
  input  logic [31:0]       cfg_wdata_i
);

  lcs_pkg::core_state_e state_q, state_d;

  // configuration
  logic signed [31:0] bias_q;
  logic [31:0]        inv_scale_q;

  // stores
  logic signed [31:0] weight_mem [lcs_pkg::MaxFeatures];
  logic [15:0]        mean_mem   [lcs_pkg::MaxFeatures];
  logic signed [31:0] weight_rd_q;
  logic [15:0]        mean_rd_q;

  // record control
  logic [lcs_pkg::FeatAw-1:0] pos_q;
  logic                       open_q;
  logic                       last_q, missing_q;
  logic [15:0]                beta_q;

  // datapath
  logic signed [48:0] prod_q;
  logic signed [63:0] acc_q;
  logic [63:0]        mag_q;
  logic               neg_q;
  logic [63:0]        hi_q, lo_q;
  logic [51:0]        logit_q;
  logic [lcs_pkg::SigAw-1:0] tidx_q;
  logic [16:0]        sig_q;
  logic [15:0]        prob_q;
  logic [15:0]        conf_q;

  lcs_pkg::out_item_t out_q;
  logic               out_valid_q;

  lcs_pkg::ent_req_t ent_req;
  lcs_pkg::ent_rsp_t ent_rsp;

  logic accept;
  logic load_c;

  assign in_ready_o  = (state_q == lcs_pkg::CoreIdle);
  assign accept      = in_valid_i & in_ready_o;
  assign load_c      = accept && (in_item_i.action == lcs_pkg::ActLoad) &&
                       (int'(in_item_i.index) < lcs_pkg::MaxFeatures);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // multiply: missing beta falls back to the training mean
  logic [15:0]        value_c;
  logic signed [48:0] prod_c;
  assign value_c = missing_q ? mean_rd_q : beta_q;
  assign prod_c  = weight_rd_q * $signed({1'b0, value_c});

  // saturating accumulate; a fresh record starts from bias in Q.31
  logic signed [63:0] base_c;
  logic signed [64:0] sum_c;
  logic signed [63:0] acc_c;
  always_comb begin
    base_c = open_q ? acc_q : (64'(bias_q) <<< 15);
    sum_c  = {base_c[63], base_c} + 65'(prod_q);
    if (sum_c[64] != sum_c[63]) acc_c = sum_c[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    else acc_c = sum_c[63:0];
  end

  // logit magnitude in Q.47, clamped just below 16
  localparam logic [51:0] LogitMax = (52'd1 << 51) - 52'd1;
  logic [63:0] lsum_c;
  logic [51:0] logit_c;
  always_comb begin
    lsum_c = (hi_q << 32) + lo_q;
    if (hi_q >= (64'd1 << 19) || lo_q >= (64'd1 << 51) || lsum_c >= (64'd1 << 51))
      logit_c = LogitMax;
    else logit_c = lsum_c[51:0];
  end

  // table index = ((L >> 20) * depth) >> 31, clamped to the last entry
  logic [46:0] tmul_c;
  logic [15:0] tsel_c;
  logic [lcs_pkg::SigAw-1:0] tidx_c;
  always_comb begin
    tmul_c = 47'(logit_q[51:20]) * 47'(lcs_pkg::SigDepth);
    tsel_c = tmul_c[46:31];
    if (int'(tsel_c) >= lcs_pkg::SigDepth) tidx_c = lcs_pkg::SigAw'(lcs_pkg::SigDepth - 1);
    else tidx_c = tsel_c[lcs_pkg::SigAw-1:0];
  end

  // probability, mirrored for negative scores
  logic [15:0] prob_c;
  always_comb begin
    if (neg_q) prob_c = 16'(17'd65536 - sig_q);
    else prob_c = sig_q[16] ? 16'hFFFF : sig_q[15:0];
  end

  assign ent_req.start = (state_q == lcs_pkg::CoreProb);
  assign ent_req.prob  = prob_c;

  lcs_entropy u_entropy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ent_req),
    .rsp_o  (ent_rsp)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lcs_pkg::CoreIdle: begin
        if (accept && in_item_i.action == lcs_pkg::ActScore) state_d = lcs_pkg::CoreMul;
      end
      lcs_pkg::CoreMul:   state_d = lcs_pkg::CoreAcc;
      lcs_pkg::CoreAcc:   state_d = last_q ? lcs_pkg::CoreMag : lcs_pkg::CoreIdle;
      lcs_pkg::CoreMag:   state_d = lcs_pkg::CoreHi;
      lcs_pkg::CoreHi:    state_d = lcs_pkg::CoreLo;
      lcs_pkg::CoreLo:    state_d = lcs_pkg::CoreLogit;
      lcs_pkg::CoreLogit: state_d = lcs_pkg::CoreIndex;
      lcs_pkg::CoreIndex: state_d = lcs_pkg::CoreTable;
      lcs_pkg::CoreTable: state_d = lcs_pkg::CoreProb;
      lcs_pkg::CoreProb:  state_d = lcs_pkg::CoreEnt;
      lcs_pkg::CoreEnt:   if (ent_rsp.done) state_d = lcs_pkg::CoreOut;
      lcs_pkg::CoreOut:   if (!out_valid_q || out_ready_i) state_d = lcs_pkg::CoreIdle;
      default:            state_d = lcs_pkg::CoreIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lcs_pkg::CoreIdle;
      bias_q      <= '0;
      inv_scale_q <= 32'd65536;
      pos_q       <= '0;
      open_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          lcs_pkg::CfgBias:     bias_q      <= cfg_wdata_i;
          lcs_pkg::CfgInvScale: inv_scale_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (state_q == lcs_pkg::CoreAcc) begin
        if (last_q) begin
          pos_q  <= '0;
          open_q <= 1'b0;
        end else begin
          open_q <= 1'b1;
          if (int'(pos_q) == lcs_pkg::MaxFeatures - 1) pos_q <= '0;
          else pos_q <= pos_q + 1'b1;
        end
      end
      if (state_q == lcs_pkg::CoreOut && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // stores: write on load, read at the record position on every accept
  always_ff @(posedge clk_i) begin
    if (load_c) begin
      weight_mem[lcs_pkg::FeatAw'(in_item_i.index)] <= in_item_i.weight;
      mean_mem[lcs_pkg::FeatAw'(in_item_i.index)]   <= in_item_i.mean;
    end
    if (accept) begin
      weight_rd_q <= weight_mem[pos_q];
      mean_rd_q   <= mean_mem[pos_q];
      beta_q      <= in_item_i.beta;
      missing_q   <= in_item_i.beta_missing;
      last_q      <= in_item_i.last;
    end
  end

  // sigmoid ROM, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == lcs_pkg::CoreTable) sig_q <= lcs_pkg::SigTable[tidx_q];
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lcs_pkg::CoreMul: prod_q <= prod_c;
      lcs_pkg::CoreAcc: acc_q  <= acc_c;
      lcs_pkg::CoreMag: begin
        neg_q <= acc_q[63];
        mag_q <= acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
      end
      lcs_pkg::CoreHi:    hi_q    <= 64'(mag_q[63:32]) * 64'(inv_scale_q);
      lcs_pkg::CoreLo:    lo_q    <= 64'(mag_q[31:0]) * 64'(inv_scale_q);
      lcs_pkg::CoreLogit: logit_q <= logit_c;
      lcs_pkg::CoreIndex: tidx_q  <= tidx_c;
      lcs_pkg::CoreProb:  prob_q  <= prob_c;
      lcs_pkg::CoreEnt:   if (ent_rsp.done) conf_q <= ent_rsp.conf;
      lcs_pkg::CoreOut: begin
        if (!out_valid_q || out_ready_i) begin
          out_q.label       <= prob_q[15];
          out_q.probability <= prob_q;
          out_q.confidence  <= conf_q;
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- sim/tb_linear_classifier_score_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_classifier_score_core
// Self-checking bench for the linear classifier score core.
// ----------------------------------------------------------------------------
// Items go in over a valid/ready channel and are scored by a local predictor
// (own sigmoid table, own log2, saturating accumulator). Each result item is
// compared field by field with the oldest expected result. A short directed
// table comes first, then the low store entries are filled, and random records
// run under several register settings and idling modes, including a long
// output hold and a drain pause. Records are closed before they run past the
// filled entries.
// ----------------------------------------------------------------------------
module tb_linear_classifier_score_core;
  import lcs_pkg::*;

  localparam int TailCycles    = 80;     // settle time after the last expected result
  localparam int WatchLimit    = 20000;  // cycles without any accepted item
  localparam int HoldCycles    = 3000;
  localparam int FilledEntries = 128;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic      cfg_we = 1'b0;
  cfg_idx_e  cfg_index = CfgBias;
  logic [31:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  linear_classifier_score_core u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // ---------------------------------------------------------------- predictor
  logic signed [31:0] weight_mem [MaxFeatures];
  logic [15:0]        mean_mem   [MaxFeatures];
  longint             score_acc;
  int unsigned        feat_pos;
  bit                 rec_open;
  logic signed [31:0] bias_reg = 32'sd0;
  logic [31:0]        inv_scale_reg = 32'd65536;
  int unsigned        sigmoid_lut [SigDepth];

  out_item_t          expected_q [$];
  int                 errors = 0;

  // sigmoid at bin midpoints, e^-x stepped by repeated multiplication
  function automatic void fill_sigmoid_lut();
    longint unsigned step_x, pos, neg, term, half, full, e, s;
    step_x = (64'd1 << 35) / SigDepth;
    pos  = 64'd1 << 32;
    neg  = 0;
    term = 64'd1 << 32;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * step_x) >> 32) / k;
      if (k % 2) neg += term;
      else pos += term;
    end
    half = pos - neg;
    full = (half * half + (64'd1 << 31)) >> 32;
    e = half;
    for (int i = 0; i < SigDepth; i++) begin
      s = (64'd1 << 32) + e;
      sigmoid_lut[i] = int'(((64'd1 << 48) + s / 2) / s);
      e = (e * full + (64'd1 << 31)) >> 32;
    end
  endfunction

  // log2(v) in Q.16, v in 1..65536: normalise, then 16 squaring steps
  function automatic int unsigned log2_fix(int unsigned v);
    int unsigned     msb, t, frac;
    longint unsigned m;
    msb = 0;
    t = v;
    frac = 0;
    while (t > 1) begin
      t >>= 1;
      msb++;
    end
    m = longint'(v) << (30 - msb);
    for (int n = 0; n < 16; n++) begin
      m = (m * m) >> 30;
      frac <<= 1;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        frac |= 1;
      end
    end
    return (msb << 16) | frac;
  endfunction

  function automatic longint unsigned entropy_term(int unsigned v);
    if (v == 0) return 0;
    return longint'(v) * longint'((32'd16 << 16) - log2_fix(v));
  endfunction

  function automatic void close_record();
    longint unsigned mag, hi, lo, logit, h;
    int unsigned     tidx, prob, h16, conf;
    out_item_t       r;
    mag = (score_acc < 0) ? -score_acc : score_acc;
    hi  = (mag >> 32) * inv_scale_reg;
    lo  = (mag & 64'hFFFF_FFFF) * inv_scale_reg;
    if (hi >= (64'd1 << 19) || lo >= (64'd1 << 51)) logit = (64'd1 << 51) - 1;
    else begin
      logit = (hi << 32) + lo;
      if (logit >= (64'd1 << 51)) logit = (64'd1 << 51) - 1;
    end
    tidx = int'(((logit >> 20) * SigDepth) >> 31);
    if (tidx >= SigDepth) tidx = SigDepth - 1;
    if (score_acc >= 0) begin
      prob = (sigmoid_lut[SigAw'(tidx)] > 65535) ? 65535 : sigmoid_lut[SigAw'(tidx)];
    end else begin
      prob = 65536 - sigmoid_lut[SigAw'(tidx)];
    end
    h    = entropy_term(prob) + entropy_term(65536 - prob);
    h16  = int'((h + 32768) >> 16);
    conf = (h16 >= 65536) ? 0 : 65536 - h16;
    if (conf > 65535) conf = 65535;
    r.label       = (prob >= 32768);
    r.probability = prob[15:0];
    r.confidence  = conf[15:0];
    expected_q.push_back(r);
  endfunction

  function automatic void predict_item(in_item_t it);
    int unsigned        addr;
    logic [15:0]        val;
    longint             base, prod;
    logic signed [64:0] sum;
    if (it.action == ActLoad) begin
      weight_mem[it.index] = it.weight;
      mean_mem[it.index]   = it.mean;
      return;
    end
    addr = feat_pos % MaxFeatures;
    val  = it.beta_missing ? mean_mem[FeatAw'(addr)] : it.beta;
    base = rec_open ? score_acc : longint'(bias_reg) * 32768;
    prod = longint'(weight_mem[FeatAw'(addr)]) * longint'(int'(val));
    sum  = 65'(base) + 65'(prod);
    if (sum > 65'sh0_7FFF_FFFF_FFFF_FFFF) score_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
    else if (sum < -65'sh0_8000_0000_0000_0000) score_acc = 64'sh8000_0000_0000_0000;
    else score_acc = sum[63:0];
    rec_open = 1'b1;
    if (!it.last) begin
      feat_pos = (addr + 1) % MaxFeatures;
      return;
    end
    close_record();
    feat_pos = 0;
    rec_open = 1'b0;
  endfunction

  // ---------------------------------------------------------------- drivers
  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;

  // output side: random stalls, or a long counted hold when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    predict_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CfgBias) bias_reg = val;
    else inv_scale_reg = val;
  endtask

  // wait for every expected result, then let trailing work finish
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (TailCycles) @(negedge clk);
  endtask

  function automatic in_item_t mk(logic act, logic [9:0] idx, logic [31:0] w,
                                  logic [15:0] mn, logic [15:0] bt, logic miss,
                                  logic lst);
    in_item_t it;
    it.action = act;
    it.index = idx;
    it.weight = w;
    it.mean = mn;
    it.beta = bt;
    it.beta_missing = miss;
    it.last = lst;
    return it;
  endfunction

  function automatic logic [31:0] rand_weight();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom;
      default: return 32'($signed($urandom_range(262143)) - 131072);
    endcase
  endfunction

  function automatic logic [15:0] rand_q15();
    case ($urandom_range(9))
      0:       return 16'd32768;
      1:       return 16'd0;
      2:       return 16'($urandom);  // outside Q1.15 range, still legal bits
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result item %p", $time, out_item);
        errors++;
      end else begin
        out_item_t want;
        want = expected_q.pop_front();
        if (out_item.label !== want.label) begin
          $display("%0t: label exp %0d got %0d", $time, want.label, out_item.label);
          errors++;
        end
        if (out_item.probability !== want.probability) begin
          $display("%0t: probability exp %0d got %0d", $time, want.probability,
                   out_item.probability);
          errors++;
        end
        if (out_item.confidence !== want.confidence) begin
          $display("%0t: confidence exp %0d got %0d", $time, want.confidence,
                   out_item.confidence);
          errors++;
        end
      end
    end
  end

  // watchdog: nothing accepted on either channel for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  in_item_t    directed [$];
  logic [31:0] bias_set [6] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000,
                                32'h0003_0000, 32'h0};
  logic [31:0] inv_set  [6] = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'd0,
                                32'd16384, 32'd65536};

  initial begin
    int len;
    fill_sigmoid_lut();
    feat_pos = 0;
    rec_open = 1'b0;
    score_acc = 0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: store extremes, ignored fields on a load, each record kind
    directed.push_back(mk(ActLoad, 10'd0, 32'h7FFF_FFFF, 16'd32768, 16'hFFFF, 1'b1, 1'b1));
    directed.push_back(mk(ActLoad, 10'd1, 32'h8000_0000, 16'd0, 16'd0, 1'b0, 1'b0));
    directed.push_back(mk(ActLoad, 10'd2, 32'h0000_0000, 16'hFFFF, 16'd0, 1'b0, 1'b0));
    directed.push_back(mk(ActLoad, 10'd3, 32'h0001_0000, 16'd16384, 16'd0, 1'b0, 1'b0));
    directed.push_back(mk(ActLoad, 10'd1023, 32'hFFFF_FFFF, 16'd32768, 16'd0, 1'b0, 1'b0));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd32768, 1'b0, 1'b1)); // max +
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1));     // missing
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b1));     // zero
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd32768, 1'b0, 1'b1)); // max -
    directed.push_back(mk(ActScore, 10'h3FF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b0));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd0, 1'b1, 1'b1));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd5, 1'b0, 1'b0));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd0, 1'b0, 1'b0));
    directed.push_back(mk(ActScore, 10'd0, 32'd0, 16'd0, 16'd32768, 1'b0, 1'b1));
    foreach (directed[i]) send_item(directed[i]);
    drain();

    // fill the low entries that random records walk through
    for (int i = 0; i < FilledEntries; i++)
      send_item(mk(ActLoad, 10'(i), rand_weight(), rand_q15(), 16'($urandom),
                   1'($urandom), 1'($urandom)));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CfgBias, (ph == 5) ? $urandom : bias_set[ph]);
      write_reg(CfgInvScale, (ph == 5) ? $urandom : inv_set[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
        default: begin src_idle_pct = 8; sink_stall_pct = 8; end
      endcase
      if (ph == 0) hold_left = HoldCycles;  // output blocked while input streams
      for (int n = 0; n < 100; n += len) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(40) + 1 : $urandom_range(6) + 1;
        if ($urandom_range(7) == 0)
          send_item(mk(ActLoad, 10'($urandom_range(FilledEntries - 1)), rand_weight(),
                       rand_q15(), 16'($urandom), 1'($urandom), 1'($urandom)));
        // a record left open at its final item is rare noise and runs on into the
        // next batch; records are closed at the top filled entry
        for (int f = 0; f < len; f++)
          send_item(mk(ActScore, 10'($urandom), $urandom, 16'($urandom), rand_q15(),
                       ($urandom_range(4) == 0),
                       ((f == len - 1) && ($urandom_range(19) != 0)) ||
                       (feat_pos >= FilledEntries - 1)));
        if (ph == 3 && n < 10) drain();  // sender pauses until all is out
      end
      drain();
    end

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
